// File: rtl/core/bdi_pkg.sv
`default_nettype none

package bdi_pkg;

    // Default number of ring entries.
    localparam int DEPTH_DEF = 16;

    // Field widths of one request and one response.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Action codes. Codes six and seven are unused and change nothing.
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_AT    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WRITE_AT   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load_data;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_hit;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bdi_ram.sv
`default_nettype none

module bdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bdi_ctrl.sv
`default_nettype none

module bdi_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output bdi_pkg::dp_cmd_t        cmd,
    input  wire bdi_pkg::dp_stat_t  stat
);

    bdi_pkg::state_t state_reg;
    bdi_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdi_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdi_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.rd_hit ? bdi_pkg::S_READ : bdi_pkg::S_RESP;
                end
            end
            bdi_pkg::S_READ:
            begin
                state_next = bdi_pkg::S_RESP;
            end
            bdi_pkg::S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = bdi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdi_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_stall     = 1'b1;
        rsp_valid     = 1'b0;
        cmd.take      = 1'b0;
        cmd.load_data = 1'b0;
        unique case (state_reg)
            bdi_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                cmd.take  = req_valid;
            end
            bdi_pkg::S_READ:
            begin
                cmd.load_data = 1'b1;
            end
            bdi_pkg::S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // A read capture always follows the request that started it.
    a_load_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_data |-> $past(cmd.take) && $past(stat.rd_hit))
        else $error("read capture without a preceding read request");

    // No new request is taken while a response is still pending.
    a_no_take_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !cmd.take)
        else $error("request taken while a response is pending");

    // A stalled response stays offered.
    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("stalled response was withdrawn");

endmodule

`default_nettype wire

// File: rtl/core/bdi_dpath.sv
`default_nettype none

module bdi_dpath #(
    parameter int DEPTH = bdi_pkg::DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bdi_pkg::req_t      req,
    output bdi_pkg::rsp_t           rsp,
    input  wire bdi_pkg::dp_cmd_t   cmd,
    output bdi_pkg::dp_stat_t       stat
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CMP_W  = (CNT_W > bdi_pkg::INDEX_W) ? CNT_W : bdi_pkg::INDEX_W;
    localparam int IDXX_W = (PTR_W > bdi_pkg::INDEX_W) ? PTR_W : bdi_pkg::INDEX_W;
    localparam int OCNT_W = (CNT_W > bdi_pkg::COUNT_W) ? CNT_W : bdi_pkg::COUNT_W;

    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [bdi_pkg::VALUE_W-1:0]  data_reg;
    logic [bdi_pkg::STATUS_W-1:0] status_reg;
    logic [bdi_pkg::STATUS_W-1:0] status_next;

    logic                is_empty;
    logic                is_full;
    logic                in_range;
    logic [IDXX_W-1:0]   idx_wide;
    logic [PTR_W-1:0]    logical;
    logic [SUM_W-1:0]    slot_sum;
    logic [PTR_W-1:0]    slot;
    logic [PTR_W-1:0]    head_dec;
    logic [PTR_W-1:0]    head_inc;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic                rd_hit;
    logic [bdi_pkg::VALUE_W-1:0] rd_data;
    logic [OCNT_W-1:0]   count_out;

    // Occupancy and index checks.
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign in_range = (CMP_W'(req.index) < CMP_W'(count_reg));

    // Ring slot of a logical position: head plus offset, wrapped once.
    assign idx_wide = IDXX_W'(req.index);
    assign logical  = (req.action == bdi_pkg::ACT_PUSH_BACK) ?
                      count_reg[PTR_W-1:0] : idx_wide[PTR_W-1:0];
    assign slot_sum = {1'b0, head_reg} + {1'b0, logical};
    assign slot     = (slot_sum >= SUM_W'(DEPTH)) ?
                      PTR_W'(slot_sum - SUM_W'(DEPTH)) : slot_sum[PTR_W-1:0];

    // Head moves one slot either way with wraparound.
    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Action decode.
    always_comb
    begin
        status_next = bdi_pkg::ST_OK;
        head_next   = head_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = slot;
        rd_hit      = 1'b0;
        unique case (req.action) inside
            bdi_pkg::ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = bdi_pkg::ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            bdi_pkg::ACT_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = bdi_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            bdi_pkg::ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = bdi_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdi_pkg::ACT_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = bdi_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bdi_pkg::ACT_READ_AT, bdi_pkg::ACT_WRITE_AT:
            begin
                if (is_empty)
                begin
                    status_next = bdi_pkg::ST_EMPTY;
                end
                else if (!in_range)
                begin
                    status_next = bdi_pkg::ST_RANGE;
                end
                else if (req.action == bdi_pkg::ACT_READ_AT)
                begin
                    rd_hit = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                status_next = bdi_pkg::ST_OK;
            end
        endcase
    end

    assign stat.rd_hit = rd_hit;

    // Element store.
    bdi_ram #(
        .WIDTH (bdi_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.take && wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (cmd.take && rd_hit),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Response payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            status_reg <= status_next;
            data_reg   <= '0;
        end
        else if (cmd.load_data)
        begin
            data_reg <= rd_data;
        end
    end

    assign count_out  = OCNT_W'(count_reg);
    assign rsp.data   = data_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = count_out[bdi_pkg::COUNT_W-1:0];

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above ring size");

    // A refused request leaves pointer and count untouched.
    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && (status_next != bdi_pkg::ST_OK)
        |=> (count_reg == $past(count_reg)) && (head_reg == $past(head_reg)))
        else $error("refused request changed the queue state");

    // A successful pop removes exactly one element.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && (status_next == bdi_pkg::ST_OK)
        && ((req.action == bdi_pkg::ACT_POP_FRONT) || (req.action == bdi_pkg::ACT_POP_BACK))
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove one element");

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_indexed_top.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit words kept in a ring of DEPTH
// entries with a head pointer and an element count. Each request pushes or
// pops at either end, or reads or writes the element at a position counted
// from the front; every request returns one response with the word read
// (read_at only, zero otherwise), a status code and the count after the
// action. Requests that cannot be served are flagged and change nothing.
// The block handles one request at a time: after acceptance it offers the
// response, holds it while the response is stalled, and only then accepts
// the next request; a successful read_at passes through an extra state for
// the registered read of the element memory.
module bounded_deque_indexed_top #(
    parameter int DEPTH = bdi_pkg::DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bdi_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bdi_pkg::rsp_t       rsp
);

    bdi_pkg::dp_cmd_t  cmd;
    bdi_pkg::dp_stat_t stat;

    // Request sequencer.
    bdi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Ring storage, pointers and response registers.
    bdi_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire
